// File: sv/mbtf_pkg.sv
package mbtf_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] FUNC_READ_REGS   = 2'd0;
   localparam logic [1:0] FUNC_WRITE_REG   = 2'd1;
   localparam logic [1:0] FUNC_READ_COILS  = 2'd2;
   localparam logic [1:0] FUNC_WRITE_COILS = 2'd3;

   // register byte orders
   localparam logic [1:0] ORDER_ABCD = 2'd0;
   localparam logic [1:0] ORDER_BADC = 2'd1;
   localparam logic [1:0] ORDER_CDAB = 2'd2;
   localparam logic [1:0] ORDER_DCBA = 2'd3;

   // function codes
   localparam logic [7:0] FC_READ_COILS     = 8'h01;
   localparam logic [7:0] FC_READ_REGS      = 8'h03;
   localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
   localparam logic [7:0] FC_WRITE_REG      = 8'h06;
   localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGS     = 8'h10;

   localparam logic [7:0]  LEN_SHORT      = 8'h06;
   localparam logic [7:0]  LEN_WIDE       = 8'h0B;
   localparam logic [7:0]  LEN_COIL_BASE  = 8'h07;
   localparam logic [15:0] COIL_ON        = 16'hFF00;
   localparam logic [7:0]  WIDE_REG_COUNT = 8'h02;
   localparam logic [7:0]  WIDE_BYTES     = 8'h04;

   // configuration register indexes
   localparam logic CSR_UNIT_ID        = 1'b0;
   localparam logic CSR_TRANSACTION_ID = 1'b1;

   localparam int MAX_COIL_BYTES_DEF = 32;
   localparam int HDR_BYTES          = 17;   // longest fixed frame image
   localparam int LEN_W              = 7;    // frame length up to 127
   localparam int REQ_DATA_W         = 72;

   typedef logic [HDR_BYTES-1:0][7:0] hdr_type;

   typedef struct packed {
      hdr_type          hdr;
      logic [LEN_W-1:0] len;
      logic             err;
   } frame_type;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic       err;
      logic [7:0] data;
   } cell_type;

endpackage

// File: sv/mbtf_builder.sv
module mbtf_builder #(
   parameter int MAX_COIL_BYTES = mbtf_pkg::MAX_COIL_BYTES_DEF
) (
   input  logic [1:0]          func,
   input  logic [15:0]         start_address,
   input  logic [15:0]         item_count,
   input  logic [31:0]         write_value,
   input  logic                wide_value,
   input  logic [1:0]          byte_order,
   input  logic [7:0]          unit_id,
   input  logic [15:0]         transaction_id,
   output mbtf_pkg::frame_type frame
);
   import mbtf_pkg::*;

   logic [13:0] nbytes;
   logic        val_nz;
   logic [7:0]  va, vb, vc, vd;

   assign nbytes = 14'(({1'b0, item_count} + 17'd7) >> 3);
   assign val_nz = (write_value != 32'd0);
   assign va     = write_value[31:24];
   assign vb     = write_value[23:16];
   assign vc     = write_value[15:8];
   assign vd     = write_value[7:0];

   always_comb begin
      frame.hdr     = '0;
      frame.len     = LEN_W'(12);
      frame.err     = 1'b0;
      frame.hdr[0]  = transaction_id[15:8];
      frame.hdr[1]  = transaction_id[7:0];
      frame.hdr[5]  = LEN_SHORT;
      frame.hdr[6]  = unit_id;
      frame.hdr[8]  = start_address[15:8];
      frame.hdr[9]  = start_address[7:0];
      case (func)
         FUNC_READ_REGS, FUNC_READ_COILS: begin
            frame.hdr[7]  = (func == FUNC_READ_REGS) ? FC_READ_REGS : FC_READ_COILS;
            frame.hdr[10] = item_count[15:8];
            frame.hdr[11] = item_count[7:0];
         end
         FUNC_WRITE_REG: begin
            if (!wide_value) begin
               frame.hdr[7] = FC_WRITE_REG;
               if (byte_order == ORDER_BADC) begin
                  frame.hdr[10] = vd;
                  frame.hdr[11] = vc;
               end else begin
                  frame.hdr[10] = vc;
                  frame.hdr[11] = vd;
               end
            end else begin
               frame.hdr[5]  = LEN_WIDE;
               frame.hdr[7]  = FC_WRITE_REGS;
               frame.hdr[11] = WIDE_REG_COUNT;
               frame.hdr[12] = WIDE_BYTES;
               frame.len     = LEN_W'(HDR_BYTES);
               case (byte_order)
                  ORDER_ABCD: frame.hdr[16:13] = {vd, vc, vb, va};
                  ORDER_BADC: frame.hdr[16:13] = {vc, vd, va, vb};
                  ORDER_CDAB: frame.hdr[16:13] = {vb, va, vd, vc};
                  default:    frame.hdr[16:13] = {va, vb, vc, vd};
               endcase
            end
         end
         default: begin
            if (item_count == 16'd1) begin
               frame.hdr[7]  = FC_WRITE_COIL;
               frame.hdr[10] = val_nz ? COIL_ON[15:8] : 8'h00;
               frame.hdr[11] = COIL_ON[7:0];
            end else if (nbytes > 14'(MAX_COIL_BYTES)) begin
               // overflow: one error beat with a zero byte
               frame.hdr = '0;
               frame.len = LEN_W'(1);
               frame.err = 1'b1;
            end else begin
               frame.hdr[5]  = 8'(LEN_COIL_BASE + nbytes[7:0]);
               frame.hdr[7]  = FC_WRITE_COILS;
               frame.hdr[10] = item_count[15:8];
               frame.hdr[11] = item_count[7:0];
               frame.hdr[12] = nbytes[7:0];
               frame.hdr[13] = {7'd0, val_nz};
               frame.len     = LEN_W'(7'd13 + nbytes[6:0]);
            end
         end
      endcase
   end

endmodule

// File: sv/mbtf_cell.sv
module mbtf_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               shift,
   input  mbtf_pkg::cell_type load_value,
   input  mbtf_pkg::cell_type neighbor,
   output mbtf_pkg::cell_type cur
);
   import mbtf_pkg::*;

   cell_type cell_ff, cell_in;

   // load wins: it only happens when the row is empty or draining its final beat
   always_comb begin
      cell_in = cell_ff;
      if (load) begin
         cell_in = load_value;
      end else if (shift) begin
         cell_in = neighbor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.last <= cell_in.last;
      cell_ff.err  <= cell_in.err;
      cell_ff.data <= cell_in.data;
   end

   assign cur = cell_ff;

endmodule

// File: sv/modbus_tcp_request_framer_core.sv
// Modbus TCP request framer. Each request beat (kind on req_tuser, address,
// count, value, width and byte order on req_tdata) becomes the complete
// request frame, one byte per rsp beat: MBAP header, function code and
// payload, rsp_tlast on the final byte. A coil write whose packed byte count
// exceeds MAX_COIL_BYTES gives one beat with byte 0, tlast and tuser high.
// The whole frame image is loaded at once into a row of byte cells; the row
// shifts one byte toward the output every beat. A frame is 12 bytes, 13 +
// coil bytes, or 17 bytes (the error frame is one beat), and the
// next request is taken in the same cycle the final byte leaves, so frames
// follow back to back. The output rate of one byte per cycle while
// rsp_tready is high sets the throughput.
module modbus_tcp_request_framer_core #(
   parameter int MAX_COIL_BYTES = mbtf_pkg::MAX_COIL_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: start_address[15:0], item_count[31:16], write_value[63:32],
   //        wide_value[64], byte_order[66:65], zero fill [71:67]
   input  logic [mbtf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]  req_tuser,    // func
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic [7:0]  rsp_tdata,    // frame_byte
   output logic        rsp_tlast,    // last_byte
   output logic        rsp_tuser,    // too_many_coils
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import mbtf_pkg::*;

   // enough cells for the longest coil frame and the 32-bit register write
   localparam int NCELL = (13 + MAX_COIL_BYTES > HDR_BYTES) ? 13 + MAX_COIL_BYTES
                                                            : HDR_BYTES;

   logic [7:0]  unit_id_ff;
   logic [15:0] transaction_id_ff;

   frame_type frame;
   cell_type  cells   [NCELL+1];
   logic      load;
   logic      shift;

   // configuration registers, to be written only between requests; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_id_ff        <= 8'd1;
         transaction_id_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UNIT_ID:        unit_id_ff        <= csr_wdata[7:0];
            CSR_TRANSACTION_ID: transaction_id_ff <= csr_wdata;
            default:            ;
         endcase
      end
   end

   mbtf_builder #(
      .MAX_COIL_BYTES(MAX_COIL_BYTES)
   ) u_builder (
      .func          (req_tuser),
      .start_address (req_tdata[15:0]),
      .item_count    (req_tdata[31:16]),
      .write_value   (req_tdata[63:32]),
      .wide_value    (req_tdata[64]),
      .byte_order    (req_tdata[66:65]),
      .unit_id       (unit_id_ff),
      .transaction_id(transaction_id_ff),
      .frame         (frame)
   );

   // accept a request when the row is empty or its final beat leaves now
   assign req_tready = !cells[0].valid || (cells[0].last && rsp_tready);
   assign load       = req_tvalid && req_tready;
   // advance the row whenever the head beat is taken
   assign shift      = cells[0].valid && rsp_tready;

   // past the end of the row feed an empty cell
   assign cells[NCELL] = '0;

   for (genvar i = 0; i < NCELL; i++) begin : g_row
      // header byte this cell takes from the fixed image
      localparam int HI = (i < HDR_BYTES) ? i : 0;

      cell_type load_value;

      always_comb begin
         load_value.valid = (LEN_W'(i) < frame.len);
         load_value.last  = (LEN_W'(i) == frame.len - LEN_W'(1));
         load_value.err   = (i == 0) ? frame.err : 1'b0;
         // beyond the fixed image only zero coil bytes remain
         load_value.data  = (i < HDR_BYTES) ? frame.hdr[HI] : 8'h00;
      end

      mbtf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (load),
         .shift     (shift),
         .load_value(load_value),
         .neighbor  (cells[i+1]),
         .cur       (cells[i])
      );
   end

   // head cell is the output register
   assign rsp_tvalid = cells[0].valid;
   assign rsp_tdata  = cells[0].data;
   assign rsp_tlast  = cells[0].last;
   assign rsp_tuser  = cells[0].err;

   a_load_fills_head : assert property (@(posedge clock) disable iff (reset)
      load |=> cells[0].valid)
      else $error("accepted request left head cell empty");

   a_err_is_last : assert property (@(posedge clock) disable iff (reset)
      (cells[0].valid && cells[0].err) |-> (cells[0].last && cells[0].data == 8'h00))
      else $error("error beat not a single zero last beat");

   a_row_packed : assert property (@(posedge clock) disable iff (reset)
      cells[1].valid |-> (cells[0].valid && !cells[0].last))
      else $error("gap or stray beat behind a frame's last byte");

   a_no_early_accept : assert property (@(posedge clock) disable iff (reset)
      (cells[0].valid && !cells[0].last) |-> !req_tready)
      else $error("request taken while a frame is mid-flight");

endmodule
